// ===== rtl/core/pxst_pkg.sv =====
`default_nettype none

package pxst_pkg;

   // slot table geometry
   localparam int SLOT_COUNT = 1024;
   localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // field widths
   localparam int NODE_W = 16;
   localparam int SLOT_W = 10;
   localparam int WORD_W = 32;
   localparam int KIND_W = 2;

   // stream bus widths
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 160;

   // request kinds
   localparam logic [KIND_W-1:0] CMD_CAPTURE = 2'd0;
   localparam logic [KIND_W-1:0] CMD_ACCEPT  = 2'd1;

   // reply kinds
   localparam logic ACK_CAPTURE = 1'b0;
   localparam logic ACK_ACCEPT  = 1'b1;

   // register indexes
   localparam logic REG_NODE_IDENT = 1'b0;

   typedef struct packed {
      logic [NODE_W-1:0] node_ident;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] command;
      logic [WORD_W-1:0] proposal;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] value_proposal;
      logic [WORD_W-1:0] cmd_low;
      logic [WORD_W-1:0] cmd_high;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] from_node;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] proposal;
      logic [WORD_W-1:0] value_proposal;
      logic [WORD_W-1:0] cmd_low;
      logic [WORD_W-1:0] cmd_high;
   } rsp_type;

   // one slot of the table as held in memory
   typedef struct packed {
      logic [WORD_W-1:0] promised;
      logic [WORD_W-1:0] accepted;
      logic [WORD_W-1:0] cmd_low;
      logic [WORD_W-1:0] cmd_high;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ===== rtl/core/paxos_acceptor_slot_table.sv =====
// Paxos acceptor over a table of log slots.
// Requests come in on the req_ stream: tuser carries the request kind
// (capture or accept), tdata the proposal, slot, value proposal and the
// two command words. Replies leave on the rsp_ stream, at most one per
// request; tuser marks a capture ack or an accept ack.
// Each request first reads its slot from the table memory, which has a
// registered read port; the engine then decides, writes back and loads
// the reply register. A new request is taken only once the last one has
// left evaluation, while the reply register is free or being drained.
// The reply register parts the two sides: a request is taken while an
// earlier reply still waits; if the receiver stalls with a reply pending,
// the next request that has a reply holds in evaluation until it drains.
// After reset the slot memory is swept to zero, one slot a cycle, across
// all SLOT_COUNT slots (1024); req_tready stays low during the sweep.
// node_ident (csr address 0) resets to zero, which disables all handling.
`default_nettype none

module paxos_acceptor_slot_table (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // slave side: requests
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // req_proposal[31:0], slot[41:32], req_value_proposal[73:42],
   // req_cmd_low[105:74], req_cmd_high[137:106], zero[143:138]
   input  wire logic [pxst_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command[1:0]
   input  wire logic [pxst_pkg::KIND_W-1:0]        req_tuser,
   // master side: replies
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // from_node[15:0], ack_slot[25:16], ack_proposal[57:26],
   // ack_value_proposal[89:58], ack_cmd_low[121:90], ack_cmd_high[153:122],
   // zero[159:154]
   output logic      [pxst_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // ack_kind[0]
   output logic                                    rsp_tuser,
   // configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [2:0]                         csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready
);

   pxst_pkg::cfg_type               cfg;
   pxst_pkg::req_type               req;
   pxst_pkg::rsp_type               rsp;
   pxst_pkg::entry_type             rd_entry;
   pxst_pkg::entry_type             wr_entry;
   logic                            ram_wr_en;
   logic [pxst_pkg::SLOT_AW-1:0]    ram_wr_addr;
   logic                            ram_rd_en;
   logic [pxst_pkg::SLOT_AW-1:0]    ram_rd_addr;
   logic [pxst_pkg::ENTRY_W-1:0]    ram_rd_data;

   // unpack request beat
   assign req.command        = req_tuser;
   assign req.proposal       = req_tdata[31:0];
   assign req.slot           = req_tdata[41:32];
   assign req.value_proposal = req_tdata[73:42];
   assign req.cmd_low        = req_tdata[105:74];
   assign req.cmd_high       = req_tdata[137:106];

   // pack reply beat
   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {6'd0, rsp.cmd_high, rsp.cmd_low, rsp.value_proposal,
                       rsp.proposal, rsp.slot, rsp.from_node};

   pxst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pxst_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (wr_entry),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (rd_entry)
   );

   assign rd_entry = ram_rd_data;

   pxst_ram #(
      .WIDTH (pxst_pkg::ENTRY_W),
      .DEPTH (pxst_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/pxst_ram.sv =====
`default_nettype none

module pxst_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pxst_csr.sv =====
`default_nettype none

module pxst_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output pxst_pkg::cfg_type     cfg
);

   pxst_pkg::cfg_type cfg_ff;
   pxst_pkg::cfg_type cfg_in;
   logic              wr_hit;

   // register index sits above the byte offset
   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == pxst_pkg::REG_NODE_IDENT);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         cfg_in.node_ident = csr_pwdata[pxst_pkg::NODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == pxst_pkg::REG_NODE_IDENT) begin
         csr_prdata = {{(32 - pxst_pkg::NODE_W){1'b0}}, cfg_ff.node_ident};
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pxst_engine.sv =====
`default_nettype none

module pxst_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pxst_pkg::cfg_type             cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire pxst_pkg::req_type             req,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output pxst_pkg::rsp_type                  rsp,
   output logic                               ram_wr_en,
   output logic [pxst_pkg::SLOT_AW-1:0]       ram_wr_addr,
   output pxst_pkg::entry_type                ram_wr_data,
   output logic                               ram_rd_en,
   output logic [pxst_pkg::SLOT_AW-1:0]       ram_rd_addr,
   input  wire pxst_pkg::entry_type           ram_rd_data
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

   state_type                     state_ff, state_in;
   logic [pxst_pkg::SLOT_AW-1:0]  clear_idx_ff, clear_idx_in;
   pxst_pkg::req_type             req_ff, req_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pxst_pkg::rsp_type             rsp_ff, rsp_in;

   logic                req_fire;
   logic                slot_ok;
   logic                handle;
   logic                do_capture;
   logic                do_accept;
   logic                has_result;
   logic                out_free;
   logic                out_load;
   logic                raise_promise;
   pxst_pkg::entry_type entry;

   assign entry    = ram_rd_data;
   assign req_fire = req_valid && req_ready;

   // decision on the latched request and the slot read back
   assign slot_ok = ({{(32 - pxst_pkg::SLOT_W){1'b0}}, req_ff.slot}
                     < 32'(pxst_pkg::SLOT_COUNT));
   assign handle  = (cfg.node_ident != '0) && slot_ok;

   assign do_capture    = handle && (req_ff.command == pxst_pkg::CMD_CAPTURE);
   assign raise_promise = do_capture && (entry.promised < req_ff.proposal);
   assign do_accept     = handle && (req_ff.command == pxst_pkg::CMD_ACCEPT)
                          && (req_ff.proposal != '0) && (req_ff.cmd_low != '0)
                          && (entry.promised <= req_ff.proposal);
   assign has_result    = do_capture || do_accept;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (state_ff == ST_EVAL) && has_result && out_free;

   // next state and registered outputs
   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == pxst_pkg::SLOT_AW'(pxst_pkg::SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               req_in   = req;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!has_result || out_free) begin
               state_in = ST_IDLE;
            end
            if (out_load) begin
               rsp_valid_in      = 1'b1;
               rsp_in.from_node  = cfg.node_ident;
               rsp_in.slot       = req_ff.slot;
               if (do_accept) begin
                  rsp_in.kind           = pxst_pkg::ACK_ACCEPT;
                  rsp_in.proposal       = req_ff.proposal;
                  rsp_in.value_proposal = req_ff.value_proposal;
                  rsp_in.cmd_low        = req_ff.cmd_low;
                  rsp_in.cmd_high       = req_ff.cmd_high;
               end else begin
                  rsp_in.kind           = pxst_pkg::ACK_CAPTURE;
                  rsp_in.proposal       = entry.promised;
                  rsp_in.value_proposal = entry.accepted;
                  rsp_in.cmd_low        = entry.cmd_low;
                  rsp_in.cmd_high       = entry.cmd_high;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // memory access: clearing sweep, slot read on accept, write back on evaluation
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = pxst_pkg::SLOT_AW'(req_ff.slot);
      ram_wr_data = entry;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_idx_ff;
         ram_wr_data = '0;
      end else if (out_load && do_accept) begin
         ram_wr_en            = 1'b1;
         ram_wr_data.promised = req_ff.proposal;
         ram_wr_data.accepted = req_ff.proposal;
         ram_wr_data.cmd_low  = req_ff.cmd_low;
         ram_wr_data.cmd_high = req_ff.cmd_high;
      end else if (out_load && raise_promise) begin
         ram_wr_en            = 1'b1;
         ram_wr_data.promised = req_ff.proposal;
      end
   end

   assign ram_rd_en   = req_fire;
   assign ram_rd_addr = pxst_pkg::SLOT_AW'(req.slot);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // an accepted request is always evaluated in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EVAL))
      else $error("accepted request not evaluated");

   // a waiting reply is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("reply overwritten while stalled");

   // a promise written back never goes down
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EVAL) && ram_wr_en) |-> (ram_wr_data.promised >= entry.promised))
      else $error("promise lowered");

   // every accept ack comes with the slot being written
   assert property (@(posedge clock) disable iff (reset)
      (out_load && do_accept) |-> ram_wr_en)
      else $error("accept ack without write back");

endmodule

`default_nettype wire
